// ===== rtl/core/dos_dt_pkg.sv =====
// ----------------------------------------------------------------------------
// dos_dt_pkg
// Shared constants, widths and the cumulative month table for the
// FAT/DOS timestamp to epoch millisecond converter.
// ----------------------------------------------------------------------------
package dos_dt_pkg;

    // field and intermediate widths
    localparam int DateW    = 16;
    localparam int TimeW    = 16;
    localparam int TenthW   = 8;
    localparam int OutW     = 42;
    localparam int DaysW    = 16;   // days since epoch, max about 50500
    localparam int MonDaysW = 9;    // days before month, max 335
    localparam int TodW     = 17;   // seconds of day, max 115442
    localparam int SecsW    = 33;   // seconds since epoch
    localparam int TenMsW   = 11;   // tenths in ms, max 1990

    // calendar constants
    localparam int unsigned YearsToBase = 10;    // 1980 - 1970
    localparam int unsigned DaysPerYear = 365;
    localparam int unsigned SecPerDay   = 86400;
    localparam int unsigned SecPerHour  = 3600;
    localparam int unsigned SecPerMin   = 60;
    localparam int unsigned MsPerSec    = 1000;
    localparam int unsigned MsPerTenth  = 10;
    localparam int unsigned TenthsMax   = 199;
    localparam int unsigned Year2100Off = 120;   // 2100 - 1980, not a leap year
    localparam int unsigned Year2101Off = 121;
    localparam int unsigned MaxDays     = 50600;

    // months, after clamping to 1..12
    typedef enum logic [3:0] {
        MON_JAN = 4'd1,
        MON_FEB = 4'd2,
        MON_MAR = 4'd3,
        MON_APR = 4'd4,
        MON_MAY = 4'd5,
        MON_JUN = 4'd6,
        MON_JUL = 4'd7,
        MON_AUG = 4'd8,
        MON_SEP = 4'd9,
        MON_OCT = 4'd10,
        MON_NOV = 4'd11,
        MON_DEC = 4'd12
    } month_t;

    // days before the first of the month in a common year
    function automatic logic [MonDaysW-1:0] days_before_month(input month_t mon);
        logic [MonDaysW-1:0] d;
        begin
            unique case (mon)
                MON_JAN: d = 9'd0;
                MON_FEB: d = 9'd31;
                MON_MAR: d = 9'd59;
                MON_APR: d = 9'd90;
                MON_MAY: d = 9'd120;
                MON_JUN: d = 9'd151;
                MON_JUL: d = 9'd181;
                MON_AUG: d = 9'd212;
                MON_SEP: d = 9'd243;
                MON_OCT: d = 9'd273;
                MON_NOV: d = 9'd304;
                MON_DEC: d = 9'd334;
                default: d = 9'd0;
            endcase
            return d;
        end
    endfunction

endpackage

// ===== rtl/core/dos_datetime_to_epoch_ms.sv =====
// ----------------------------------------------------------------------------
// dos_datetime_to_epoch_ms
// Converts a packed FAT/DOS date word, time word and tenths byte into
// milliseconds since 1970-01-01 00:00:00, one request per cycle unless the output stalls.
// ----------------------------------------------------------------------------
//
// Usage:
//   Input channel (in_valid / in_ready) carries date_word, time_word and
//   tenth_units; the output channel (out_valid / out_ready) carries
//   epoch_ms. A request is taken on an edge where valid and ready are high.
//   A zero date word gives zero; month is clamped to 1..12, day 0 reads as
//   day 1, tenths count only when 1..199.
//
//   From acceptance to out_valid a request passes through four register
//   stages: field decode, day count, day-to-seconds multiply, and
//   seconds-to-ms multiply with the tenths add. Throughput is one request
//   per cycle while the receiver does not stall; the 16x17 and 33x10 constant multiplies set the stage depth.
//
//   Each stage has its own valid bit and loads when it is empty or when the
//   stage after it moves, so bubbles close up while the receiver stalls and
//   in_ready only drops once all four stages hold requests.
//   Reset clears the valid bits; no request is lost or repeated across a
//   stall. The payload registers are not reset.
//
module dos_datetime_to_epoch_ms (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [dos_dt_pkg::DateW-1:0]  date_word,
    input  logic [dos_dt_pkg::TimeW-1:0]  time_word,
    input  logic [dos_dt_pkg::TenthW-1:0] tenth_units,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dos_dt_pkg::OutW-1:0]   epoch_ms
);
    import dos_dt_pkg::*;

    // stage valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    // stage 1 payload
    logic [DaysW-1:0]    ydays1_reg;
    logic [MonDaysW-1:0] mdays1_reg;
    logic [4:0]          day01_reg;
    logic [TodW-1:0]     tod1_reg;
    logic [TenMsW-1:0]   tenms1_reg;
    logic                zero1_reg;

    // stage 2 payload
    logic [DaysW-1:0]    days2_reg;
    logic [TodW-1:0]     tod2_reg;
    logic [TenMsW-1:0]   tenms2_reg;
    logic                zero2_reg;

    // stage 3 payload
    logic [SecsW-1:0]    secs3_reg;
    logic [TenMsW-1:0]   tenms3_reg;
    logic                zero3_reg;

    // stage 4 payload
    logic [OutW-1:0]     ms4_reg;

    // decode signals
    logic [6:0]          year_off;
    logic [3:0]          mon_raw;
    logic [4:0]          day_raw;
    logic [4:0]          hour_f;
    logic [5:0]          min_f;
    logic [4:0]          sec2_f;
    month_t              mon;
    logic                leap_year;
    logic [7:0]          years_since;
    logic [7:0]          leap_base;
    logic [5:0]          leap_cnt;
    logic [DaysW-1:0]    ydays1_next;
    logic [MonDaysW-1:0] mdays1_next;
    logic [4:0]          day01_next;
    logic [TodW-1:0]     tod1_next;
    logic [TenMsW-1:0]   tenms1_next;
    logic [DaysW-1:0]    days2_next;
    logic [SecsW-1:0]    secs3_next;
    logic [OutW-1:0]     ms4_next;

    // per-stage flow control
    assign en4      = !v4_reg || out_ready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // field extraction
    assign year_off = date_word[15:9];
    assign mon_raw  = date_word[8:5];
    assign day_raw  = date_word[4:0];
    assign hour_f   = time_word[15:11];
    assign min_f    = time_word[10:5];
    assign sec2_f   = time_word[4:0];

    // month clamp
    always_comb
    begin
        priority if (mon_raw == 4'd0)
            mon = MON_JAN;
        else if (mon_raw > 4'(MON_DEC))
            mon = MON_DEC;
        else
            mon = month_t'(mon_raw);
    end

    // year base 1980 is a multiple of four, so the low bits tell leap years
    assign leap_year = (year_off[1:0] == 2'd0) && (year_off != 7'(Year2100Off));

    // leap years from 1970 through the year before: 1972, 1976, ... minus 2100
    assign years_since = 8'(year_off) + 8'(YearsToBase);
    assign leap_base   = 8'(year_off) + 8'd7;
    assign leap_cnt    = 6'(leap_base >> 2) + 6'd1
                       - ((year_off >= 7'(Year2101Off)) ? 6'd1 : 6'd0);

    // stage 1 next values
    always_comb
    begin
        ydays1_next = DaysW'(years_since) * DaysW'(DaysPerYear) + DaysW'(leap_cnt);
        mdays1_next = days_before_month(mon)
                    + (((mon > MON_FEB) && leap_year) ? 9'd1 : 9'd0);
        day01_next  = (day_raw == 5'd0) ? 5'd0 : day_raw - 5'd1;
        tod1_next   = TodW'(hour_f) * TodW'(SecPerHour)
                    + TodW'(min_f) * TodW'(SecPerMin)
                    + TodW'({sec2_f, 1'b0});
        if ((tenth_units != 8'd0) && (tenth_units <= 8'(TenthsMax)))
            tenms1_next = TenMsW'(tenth_units) * TenMsW'(MsPerTenth);
        else
            tenms1_next = '0;
    end

    // stage 2, 3 and 4 next values
    assign days2_next = ydays1_reg + DaysW'(mdays1_reg) + DaysW'(day01_reg);
    assign secs3_next = SecsW'(days2_reg) * SecsW'(SecPerDay) + SecsW'(tod2_reg);
    assign ms4_next   = zero3_reg ? '0
                      : OutW'(secs3_reg) * OutW'(MsPerSec) + OutW'(tenms3_reg);

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
        end
    end

    // stage payload registers
    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            ydays1_reg <= ydays1_next;
            mdays1_reg <= mdays1_next;
            day01_reg  <= day01_next;
            tod1_reg   <= tod1_next;
            tenms1_reg <= tenms1_next;
            zero1_reg  <= (date_word == '0);
        end
        if (en2 && v1_reg)
        begin
            days2_reg  <= days2_next;
            tod2_reg   <= tod1_reg;
            tenms2_reg <= tenms1_reg;
            zero2_reg  <= zero1_reg;
        end
        if (en3 && v2_reg)
        begin
            secs3_reg  <= secs3_next;
            tenms3_reg <= tenms2_reg;
            zero3_reg  <= zero2_reg;
        end
        if (en4 && v3_reg)
            ms4_reg <= ms4_next;
    end

    assign out_valid = v4_reg;
    assign epoch_ms  = ms4_reg;

    // input only stalls with every stage full and the receiver stalled
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v1_reg && v2_reg && v3_reg && v4_reg && !out_ready))
        else $error("input stalled with an empty stage");

    // an accepted request lands in stage one
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v1_reg)
        else $error("accepted request lost at stage one");

    // a stage holding a request keeps it while the next stage is blocked
    a_stage3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !en4) |=> (v3_reg && $stable(secs3_reg)))
        else $error("stage three request dropped during stall");

    // day count stays within the calendar range
    a_days_range: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (days2_reg <= DaysW'(MaxDays)))
        else $error("day count out of range");

endmodule

// ===== tb/tb_dos_datetime_to_epoch_ms.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dos_datetime_to_epoch_ms
// Drives FAT/DOS date, time and tenths requests with random gaps and
// random receiver stalls, and checks each epoch_ms result in order against
// an independent calendar computation.
// ----------------------------------------------------------------------------
module tb_dos_datetime_to_epoch_ms;

    import dos_dt_pkg::*;

    localparam int unsigned BaseYear  = 1980;
    localparam int unsigned EpochYear = 1970;
    localparam int          CycleLimit = 300000;
    localparam int          SettleCycles = 12;

    // days before the first of each month, common year
    localparam int unsigned CumDays [12] = '{
        0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
    };

    typedef struct {
        logic [DateW-1:0]  date_w;
        logic [TimeW-1:0]  time_w;
        logic [TenthW-1:0] tenths;
        bit                drain_first;
    } req_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [DateW-1:0]    date_word = '0;
    logic [TimeW-1:0]    time_word = '0;
    logic [TenthW-1:0]   tenth_units = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [OutW-1:0]     epoch_ms;

    req_t                req_pending [$];
    logic [OutW-1:0]     epoch_expected [$];
    int                  errors = 0;
    int                  cycles = 0;

    dos_datetime_to_epoch_ms dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .date_word   (date_word),
        .time_word   (time_word),
        .tenth_units (tenth_units),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .epoch_ms    (epoch_ms)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // milliseconds since 1970 for one packed timestamp
    function automatic logic [OutW-1:0] dos_to_epoch_ms(input logic [DateW-1:0] d,
                                                        input logic [TimeW-1:0] t,
                                                        input logic [TenthW-1:0] tn);
        int unsigned     year;
        int unsigned     prev;
        int unsigned     day;
        month_t          mon;
        bit              leap;
        longint unsigned days;
        longint unsigned secs;
        longint unsigned ms;
        begin
            if (d == '0)
                return '0;
            year = BaseYear + d[15:9];
            if (d[8:5] == 4'd0)
                mon = MON_JAN;
            else if (d[8:5] > 4'(MON_DEC))
                mon = MON_DEC;
            else
                mon = month_t'(d[8:5]);
            day  = (d[4:0] == 5'd0) ? 1 : d[4:0];
            prev = year - 1;
            leap = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
            // leap days from 1970 up to the start of this year
            days = longint'(year - EpochYear) * DaysPerYear
                 + (prev / 4 - prev / 100 + prev / 400)
                 - ((EpochYear - 1) / 4 - (EpochYear - 1) / 100 + (EpochYear - 1) / 400);
            days += CumDays[int'(mon) - 1];
            if (mon > MON_FEB && leap)
                days += 1;
            days += day - 1;
            secs = days * SecPerDay
                 + longint'(t[15:11]) * SecPerHour
                 + longint'(t[10:5]) * SecPerMin
                 + longint'(t[4:0]) * 2;
            ms = secs * MsPerSec;
            if (tn >= 1 && tn <= TenthsMax)
                ms += longint'(tn) * MsPerTenth;
            return ms[OutW-1:0];
        end
    endfunction

    function automatic logic [DateW-1:0] pack_date(input int yoff, input int mon, input int day);
        return {yoff[6:0], mon[3:0], day[4:0]};
    endfunction

    function automatic logic [TimeW-1:0] pack_time(input int hr, input int mn, input int s2);
        return {hr[4:0], mn[5:0], s2[4:0]};
    endfunction

    // idle length: mostly short, now and then long
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_req(input logic [DateW-1:0] d, input logic [TimeW-1:0] t,
                           input logic [TenthW-1:0] tn, input bit drain);
        req_t r;
        begin
            r.date_w      = d;
            r.time_w      = t;
            r.tenths      = tn;
            r.drain_first = drain;
            req_pending.push_back(r);
        end
    endtask

    task automatic report(input string what);
        begin
            errors++;
            $display("mismatch at cycle %0d: %s", cycles, what);
        end
    endtask

    // request driver
    int gap_left = 0;
    int send_calm = 0;
    always @(posedge clk or negedge rst_n)
    begin
        req_t nxt;
        logic busy;
        int   r;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            date_word   <= '0;
            time_word   <= '0;
            tenth_units <= '0;
            gap_left    <= 0;
            send_calm   <= 0;
        end
        else
        begin
            busy = in_valid;
            if (in_valid && in_ready)
            begin
                epoch_expected.push_back(dos_to_epoch_ms(date_word, time_word, tenth_units));
                busy = 1'b0;
            end
            if (busy)
            begin
                // hold the request until it is taken
            end
            else if (gap_left != 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (req_pending.size() != 0 &&
                     (!req_pending[0].drain_first || epoch_expected.size() == 0))
            begin
                nxt = req_pending.pop_front();
                date_word   <= nxt.date_w;
                time_word   <= nxt.time_w;
                tenth_units <= nxt.tenths;
                in_valid    <= 1'b1;
                if (send_calm != 0)
                begin
                    gap_left  <= 0;
                    send_calm <= send_calm - 1;
                end
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 3)
                        send_calm <= 50;
                    gap_left <= (r < 55) ? 0 : pick_gap();
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stalls
    int stall_left = 0;
    int recv_calm = 0;
    always @(posedge clk or negedge rst_n)
    begin
        logic [OutW-1:0] want;
        int              r;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
            recv_calm  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (epoch_expected.size() == 0)
                begin
                    report($sformatf("unexpected result epoch_ms=%0d", epoch_ms));
                end
                else
                begin
                    want = epoch_expected.pop_front();
                    if (epoch_ms !== want)
                        report($sformatf("epoch_ms got %0d want %0d", epoch_ms, want));
                end
            end
            if (stall_left != 0)
            begin
                out_ready  <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if (recv_calm != 0)
            begin
                out_ready <= 1'b1;
                recv_calm <= recv_calm - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                r = $urandom_range(0, 99);
                if (r < 4)
                    recv_calm <= 60;
                else if (r < 30)
                    stall_left <= pick_gap();
            end
        end
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("dos_datetime_to_epoch_ms test failed");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin
        int yoff;
        int roll;

        // zero date word, with and without other fields set
        add_req('0, '0, '0, 1'b0);
        add_req('0, 16'hFFFF, 8'hFF, 1'b0);
        // first representable instant and the largest fields
        add_req(pack_date(0, 1, 1), '0, '0, 1'b0);
        add_req(16'hFFFF, 16'hFFFF, 8'd199, 1'b0);
        // month zero and day zero, month above twelve
        add_req(pack_date(5, 0, 0), pack_time(1, 2, 3), 8'd1, 1'b0);
        add_req(pack_date(5, 13, 10), '0, '0, 1'b0);
        add_req(pack_date(5, 15, 31), '0, '0, 1'b0);
        // leap rules: 1980, 2000 leap, 2100 not
        add_req(pack_date(0, 3, 1), '0, '0, 1'b0);
        add_req(pack_date(20, 2, 29), '0, '0, 1'b0);
        add_req(pack_date(20, 3, 1), '0, '0, 1'b0);
        add_req(pack_date(120, 2, 29), '0, '0, 1'b0);
        add_req(pack_date(120, 3, 1), '0, '0, 1'b0);
        add_req(pack_date(121, 3, 1), '0, '0, 1'b0);
        // day past the end of the month, last day of a year
        add_req(pack_date(1, 2, 31), '0, '0, 1'b0);
        add_req(pack_date(44, 12, 31), pack_time(23, 59, 29), 8'd1, 1'b0);
        // unclamped time fields, tenths out of range
        add_req(pack_date(10, 6, 15), pack_time(31, 63, 31), 8'd200, 1'b0);
        add_req(pack_date(10, 6, 15), 16'h0001, 8'd255, 1'b0);
        add_req(pack_date(127, 1, 1), '0, 8'd199, 1'b1);
        add_req(16'h0001, 16'h8000, 8'h80, 1'b0);
        add_req(16'h8000, 16'h7FFF, 8'd2, 1'b0);

        // random requests, mostly well-formed timestamps
        for (int i = 0; i < 400; i++)
        begin
            roll = $urandom_range(0, 9);
            if (roll < 7)
            begin
                yoff = $urandom_range(0, 127);
                add_req(pack_date(yoff, $urandom_range(1, 12), $urandom_range(1, 31)),
                        pack_time($urandom_range(0, 23), $urandom_range(0, 59),
                                  $urandom_range(0, 29)),
                        TenthW'(($urandom_range(0, 9) < 8) ? $urandom_range(0, 199)
                                                           : $urandom_range(0, 255)),
                        (i == 150 || i == 300));
            end
            else
            begin
                add_req(DateW'($urandom_range(0, 16'hFFFF)),
                        TimeW'($urandom_range(0, 16'hFFFF)),
                        TenthW'($urandom_range(0, 255)), 1'b0);
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (req_pending.size() != 0 || in_valid || epoch_expected.size() != 0)
            @(negedge clk);
        repeat (SettleCycles) @(negedge clk);

        if (epoch_expected.size() != 0)
            report($sformatf("%0d results never arrived", epoch_expected.size()));
        if (errors == 0)
            $display("dos_datetime_to_epoch_ms test passed");
        else
            $display("dos_datetime_to_epoch_ms test failed");
        $finish;
    end

endmodule
